>>> rtl/bank_mapper_with_realtime_clock_defines.svh
// ---------------------------------------------------------------------------
// Bank mapper assertion macros
// Shared property templates for the checker of the bank mapper.
// ---------------------------------------------------------------------------
`ifndef BANK_MAPPER_WITH_REALTIME_CLOCK_DEFINES_SVH
`define BANK_MAPPER_WITH_REALTIME_CLOCK_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define BMRTC_ASSERT_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define BMRTC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/bmrtc_pkg.sv
// ---------------------------------------------------------------------------
// Bank mapper package
// Request and result codes and size constants of the cartridge bank mapper.
// ---------------------------------------------------------------------------
`default_nettype none

package bmrtc_pkg;

    localparam int unsigned FUNC_W       = 2;
    localparam int unsigned ADDR_W       = 16;
    localparam int unsigned DATA_W       = 8;
    localparam int unsigned MEM_ADDR_W   = 22;
    localparam int unsigned CNT_W        = 23;
    localparam int unsigned CLOCK_BYTES  = 5;
    localparam int unsigned CLOCK_IDX_W  = 3;
    localparam int unsigned PADDR_W      = 3;
    localparam int unsigned PDATA_W      = 32;

    localparam int unsigned TICKS_PER_SECOND_DEF = 4194304;

    localparam logic [3:0] ROM_EXP_RESET  = 4'd11;
    localparam logic [2:0] RAM_CODE_RESET = 3'd5;
    localparam logic [3:0] ROM_EXP_MAX    = 4'd12;
    localparam logic [3:0] ROM_EXP_7BIT   = 4'd11;

    localparam logic [7:0] SEC_LAST  = 8'd59;
    localparam logic [7:0] MIN_LAST  = 8'd59;
    localparam logic [7:0] HOUR_LAST = 8'd23;
    localparam logic [7:0] DAY_LAST  = 8'd255;

    localparam logic [7:0] SEL_CLOCK_FIRST = 8'h08;
    localparam logic [7:0] SEL_CLOCK_LAST  = 8'h0C;
    localparam logic [7:0] SEL_RAM_LIMIT   = 8'h04;
    localparam logic [7:0] UNMAPPED_READ   = 8'hFF;

    typedef enum logic [1:0] {
        FUNC_READ  = 2'd0,
        FUNC_WRITE = 2'd1,
        FUNC_TICK  = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        TGT_NONE  = 2'd0,
        TGT_ROM   = 2'd1,
        TGT_RAM   = 2'd2,
        TGT_CLOCK = 2'd3
    } target_t;

    typedef enum logic {
        REG_ROM_SIZE_EXP  = 1'b0,
        REG_RAM_SIZE_CODE = 1'b1
    } reg_index_t;

endpackage

`default_nettype wire

>>> rtl/bank_mapper_with_realtime_clock.sv
// ---------------------------------------------------------------------------
// Bank mapper with real-time clock
// Cartridge bank controller: maps bus reads and writes onto ROM, RAM or
// clock registers and advances a real-time clock on tick requests.
// ---------------------------------------------------------------------------
// Channel  Dir  Carries
// s_       in   func, addr, wdata (bus read, bus write or clock tick)
// m_       out  target, mem_addr, ram_write, ram_wdata, rdata
// APB      in   rom_size_exp at 0x0, ram_size_code at 0x4
//
// Each request is decoded and its result sits in the output register from
// the next cycle on; one request is taken per cycle while s_ready is high.
// The single output register sets the rate: s_ready is low only while it
// holds a result that m_ready does not take in the same cycle.
// aresetn is synchronous and clears all control, bank and clock state.
// ---------------------------------------------------------------------------
`default_nettype none

module bank_mapper_with_realtime_clock #(
    parameter int unsigned TICKS_PER_SECOND = bmrtc_pkg::TICKS_PER_SECOND_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    // Request channel.
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic [bmrtc_pkg::FUNC_W-1:0]       s_func,
    input  wire logic [bmrtc_pkg::ADDR_W-1:0]       s_addr,
    input  wire logic [bmrtc_pkg::DATA_W-1:0]       s_wdata,
    // Result channel.
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic [1:0]                              m_target,
    output logic [bmrtc_pkg::MEM_ADDR_W-1:0]        m_mem_addr,
    output logic                                    m_ram_write,
    output logic [bmrtc_pkg::DATA_W-1:0]            m_ram_wdata,
    output logic [bmrtc_pkg::DATA_W-1:0]            m_rdata,
    // Configuration port.
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [bmrtc_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [bmrtc_pkg::PDATA_W-1:0]      pwdata,
    output logic [bmrtc_pkg::PDATA_W-1:0]           prdata,
    output logic                                    pready
);

    localparam int unsigned CNT_W   = bmrtc_pkg::CNT_W;
    localparam int unsigned MA_W    = bmrtc_pkg::MEM_ADDR_W;
    localparam int unsigned DW      = bmrtc_pkg::DATA_W;
    localparam int unsigned NBYTES  = bmrtc_pkg::CLOCK_BYTES;
    localparam int unsigned IDX_W   = bmrtc_pkg::CLOCK_IDX_W;
    localparam logic [CNT_W:0] TICK_LIMIT = (CNT_W + 1)'(TICKS_PER_SECOND);

    // Configuration registers.
    logic [3:0] rom_exp_reg;
    logic [2:0] ram_code_reg;

    // Controller state.
    logic [7:0]       rom_bank_reg, rom_bank_next;
    logic [7:0]       select_reg, select_next;
    logic             armed_reg, armed_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [DW-1:0]    live_reg [NBYTES];
    logic [DW-1:0]    live_next [NBYTES];
    logic [DW-1:0]    latched_reg [NBYTES];
    logic [DW-1:0]    latched_next [NBYTES];

    // Result register.
    logic                 m_valid_reg;
    bmrtc_pkg::target_t   m_target_reg, target_next;
    logic [MA_W-1:0]      m_mem_addr_reg, mem_addr_next;
    logic                 m_ram_write_reg, ram_write_next;
    logic [DW-1:0]        m_ram_wdata_reg, ram_wdata_next;
    logic [DW-1:0]        m_rdata_reg, rdata_next;

    logic             accept;
    logic             cfg_write;
    logic [3:0]       rom_exp_eff;
    logic [MA_W-1:0]  rom_mask;
    logic [MA_W-1:0]  ram_mask;
    logic [CNT_W:0]   count_inc;
    logic [7:0]       bank_value;
    logic [IDX_W-1:0] clock_idx;
    logic             is_write;
    logic             sec_wrap, min_wrap, hour_wrap, day_wrap;

    assign s_ready   = !m_valid_reg || m_ready;
    assign accept    = s_valid && s_ready;
    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;

    // Configuration port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_exp_reg  <= bmrtc_pkg::ROM_EXP_RESET;
            ram_code_reg <= bmrtc_pkg::RAM_CODE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == bmrtc_pkg::REG_ROM_SIZE_EXP) begin
                rom_exp_reg <= pwdata[3:0];
            end else begin
                ram_code_reg <= pwdata[2:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == bmrtc_pkg::REG_ROM_SIZE_EXP) begin
            prdata = {28'd0, rom_exp_reg};
        end else begin
            prdata = {29'd0, ram_code_reg};
        end
    end

    // Address masks follow the configured memory sizes.
    assign rom_exp_eff = (rom_exp_reg > bmrtc_pkg::ROM_EXP_MAX) ? bmrtc_pkg::ROM_EXP_MAX
                                                                 : rom_exp_reg;
    assign rom_mask = MA_W'(((MA_W + 1)'(1) << (5'(rom_exp_eff) + 5'd10)) - (MA_W + 1)'(1));
    assign ram_mask = MA_W'(((MA_W + 1)'(1) << (5'(ram_code_reg) + 5'd10)) - (MA_W + 1)'(1));

    assign count_inc  = {1'b0, count_reg} + (CNT_W + 1)'(1);
    assign bank_value = (rom_exp_reg <= bmrtc_pkg::ROM_EXP_7BIT) ? {1'b0, s_wdata[6:0]}
                                                                  : s_wdata;
    assign clock_idx  = IDX_W'(select_reg - bmrtc_pkg::SEL_CLOCK_FIRST);
    assign is_write   = (s_func == bmrtc_pkg::FUNC_WRITE);

    assign sec_wrap  = (live_reg[0] == bmrtc_pkg::SEC_LAST);
    assign min_wrap  = (live_reg[1] == bmrtc_pkg::MIN_LAST);
    assign hour_wrap = (live_reg[2] == bmrtc_pkg::HOUR_LAST);
    assign day_wrap  = (live_reg[3] == bmrtc_pkg::DAY_LAST);

    // Decode one request and work out the next state.
    always_comb begin
        rom_bank_next  = rom_bank_reg;
        select_next    = select_reg;
        armed_next     = armed_reg;
        count_next     = count_reg;
        live_next      = live_reg;
        latched_next   = latched_reg;
        target_next    = bmrtc_pkg::TGT_NONE;
        mem_addr_next  = '0;
        ram_write_next = 1'b0;
        ram_wdata_next = '0;
        rdata_next     = '0;

        case (s_func)
            bmrtc_pkg::FUNC_TICK: begin
                if (count_inc == TICK_LIMIT) begin
                    count_next = '0;
                    live_next[0] = sec_wrap ? 8'd0 : live_reg[0] + 8'd1;
                    if (sec_wrap) begin
                        live_next[1] = min_wrap ? 8'd0 : live_reg[1] + 8'd1;
                        if (min_wrap) begin
                            live_next[2] = hour_wrap ? 8'd0 : live_reg[2] + 8'd1;
                            if (hour_wrap) begin
                                live_next[3] = live_reg[3] + 8'd1;
                                if (day_wrap) begin
                                    live_next[4] = {1'b1, live_reg[4][6:1], ~live_reg[4][0]};
                                end
                            end
                        end
                    end
                end else begin
                    count_next = count_inc[CNT_W-1:0];
                end
            end
            bmrtc_pkg::FUNC_READ, bmrtc_pkg::FUNC_WRITE: begin
                priority if (!s_addr[15] && is_write) begin
                    unique case (s_addr[14:13])
                        2'b01: rom_bank_next = (bank_value == 8'd0) ? 8'd1 : bank_value;
                        2'b10: select_next = s_wdata;
                        2'b11: begin
                            if (!armed_reg) begin
                                armed_next = (s_wdata == 8'd0);
                            end else begin
                                if (s_wdata == 8'd1) begin
                                    latched_next = live_reg;
                                end
                                armed_next = 1'b0;
                            end
                        end
                        default: ;
                    endcase
                end else if (!s_addr[15] && !s_addr[14]) begin
                    target_next   = bmrtc_pkg::TGT_ROM;
                    mem_addr_next = {8'd0, s_addr[13:0]} & rom_mask;
                end else if (!s_addr[15]) begin
                    target_next   = bmrtc_pkg::TGT_ROM;
                    mem_addr_next = {rom_bank_reg, s_addr[13:0]} & rom_mask;
                end else if (s_addr[15:13] == 3'b101) begin
                    if (select_reg < bmrtc_pkg::SEL_RAM_LIMIT && ram_code_reg != 3'd0) begin
                        target_next   = bmrtc_pkg::TGT_RAM;
                        mem_addr_next = {7'd0, select_reg[1:0], s_addr[12:0]} & ram_mask;
                        if (is_write) begin
                            ram_write_next = 1'b1;
                            ram_wdata_next = s_wdata;
                        end
                    end else if (select_reg >= bmrtc_pkg::SEL_CLOCK_FIRST
                                 && select_reg <= bmrtc_pkg::SEL_CLOCK_LAST) begin
                        target_next = bmrtc_pkg::TGT_CLOCK;
                        if (is_write) begin
                            latched_next[clock_idx] = s_wdata;
                        end else begin
                            rdata_next = latched_reg[clock_idx];
                        end
                    end
                end
                if (!is_write && target_next == bmrtc_pkg::TGT_NONE) begin
                    rdata_next = bmrtc_pkg::UNMAPPED_READ;
                end
            end
            default: ;
        endcase
    end

    // Controller and clock state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rom_bank_reg <= 8'd1;
            select_reg   <= '0;
            armed_reg    <= 1'b0;
            count_reg    <= '0;
            for (int i = 0; i < NBYTES; i++) begin
                live_reg[i]    <= '0;
                latched_reg[i] <= '0;
            end
        end else if (accept) begin
            rom_bank_reg <= rom_bank_next;
            select_reg   <= select_next;
            armed_reg    <= armed_next;
            count_reg    <= count_next;
            live_reg     <= live_next;
            latched_reg  <= latched_next;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s_ready) begin
            m_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_target_reg    <= target_next;
            m_mem_addr_reg  <= mem_addr_next;
            m_ram_write_reg <= ram_write_next;
            m_ram_wdata_reg <= ram_wdata_next;
            m_rdata_reg     <= rdata_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_target    = m_target_reg;
    assign m_mem_addr  = m_mem_addr_reg;
    assign m_ram_write = m_ram_write_reg;
    assign m_ram_wdata = m_ram_wdata_reg;
    assign m_rdata     = m_rdata_reg;

endmodule

`default_nettype wire

>>> rtl/bmrtc_checker.sv
// ---------------------------------------------------------------------------
// Bank mapper checker
// Port-level properties of the bank mapper, bound to its top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "bank_mapper_with_realtime_clock_defines.svh"

module bmrtc_checker (
    input wire logic                               aclk,
    input wire logic                               aresetn,
    input wire logic                               s_ready,
    input wire logic                               m_valid,
    input wire logic                               m_ready,
    input wire logic [1:0]                         m_target,
    input wire logic [bmrtc_pkg::MEM_ADDR_W-1:0]   m_mem_addr,
    input wire logic                               m_ram_write,
    input wire logic [bmrtc_pkg::DATA_W-1:0]       m_ram_wdata,
    input wire logic [bmrtc_pkg::DATA_W-1:0]       m_rdata
);

    `BMRTC_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_target) && $stable(m_mem_addr) && $stable(m_ram_write) && $stable(m_ram_wdata) && $stable(m_rdata), "Stalled result changed.")
    `BMRTC_ASSERT_IMPLY(a_ready_when_empty, aclk, aresetn, !m_valid, s_ready, "Request refused while the output register is empty.")
    `BMRTC_ASSERT_IMPLY(a_write_is_ram, aclk, aresetn, m_valid && m_ram_write, m_target == bmrtc_pkg::TGT_RAM, "RAM write strobe outside a RAM access.")
    `BMRTC_ASSERT_IMPLY(a_none_no_addr, aclk, aresetn, m_valid && m_target == bmrtc_pkg::TGT_NONE, m_mem_addr == '0 && !m_ram_write && m_ram_wdata == '0, "Unmapped result carries an address or write.")

endmodule

bind bank_mapper_with_realtime_clock bmrtc_checker u_bmrtc_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_target    (m_target),
    .m_mem_addr  (m_mem_addr),
    .m_ram_write (m_ram_write),
    .m_ram_wdata (m_ram_wdata),
    .m_rdata     (m_rdata)
);

`default_nettype wire

>>> verif/tb_bank_mapper_with_realtime_clock.sv
// ---------------------------------------------------------------------------
// Testbench for the bank mapper with real-time clock
// Drives bus reads, bus writes and clock ticks into the mapper. Listed
// directed rows carry their own results; the rest come from an in-bench
// model of the bank, select, latch and clock state. The run steps through
// several ROM and RAM size settings under varied request gaps and result
// stalls, and checks every result field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bank_mapper_with_realtime_clock;

    localparam int unsigned TICKS_PER_SEC = bmrtc_pkg::TICKS_PER_SECOND_DEF;
    localparam int unsigned BURST_TICKS   = 40;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned STALL_LIMIT   = 5000;
    localparam int unsigned N_DIRECTED    = 25;
    localparam int unsigned N_PHASES      = 8;

    localparam logic [1:0] FUNC_RESERVED = 2'd3;
    localparam logic [7:0] DAY_MSB_BIT   = 8'h01;
    localparam logic [7:0] DAY_CARRY_BIT = 8'h80;
    localparam logic [3:0][7:0] CLOCK_LAST = {bmrtc_pkg::DAY_LAST, bmrtc_pkg::HOUR_LAST,
                                              bmrtc_pkg::MIN_LAST, bmrtc_pkg::SEC_LAST};

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] addr;
        logic [7:0]  wdata;
    } request_t;

    typedef struct packed {
        logic [1:0]                       target;
        logic [bmrtc_pkg::MEM_ADDR_W-1:0] mem_addr;
        logic                             ram_write;
        logic [bmrtc_pkg::DATA_W-1:0]     ram_wdata;
        logic [bmrtc_pkg::DATA_W-1:0]     rdata;
    } bus_result_t;

    typedef struct packed {
        request_t    req;
        logic        listed;
        bus_result_t result;
    } stimulus_row_t;

    typedef struct packed {
        logic [3:0]  rom_exp;
        logic [2:0]  ram_code;
        logic [6:0]  send_idle;
        logic [6:0]  recv_stall;
        logic [15:0] n_requests;
        logic        hold;
        logic        pause;
    } phase_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic [bmrtc_pkg::FUNC_W-1:0]     s_func = bmrtc_pkg::FUNC_READ;
    logic [bmrtc_pkg::ADDR_W-1:0]     s_addr = '0;
    logic [bmrtc_pkg::DATA_W-1:0]     s_wdata = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [1:0]                       m_target;
    logic [bmrtc_pkg::MEM_ADDR_W-1:0] m_mem_addr;
    logic                             m_ram_write;
    logic [bmrtc_pkg::DATA_W-1:0]     m_ram_wdata;
    logic [bmrtc_pkg::DATA_W-1:0]     m_rdata;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [bmrtc_pkg::PADDR_W-1:0]    paddr = '0;
    logic [bmrtc_pkg::PDATA_W-1:0]    pwdata = '0;
    logic [bmrtc_pkg::PDATA_W-1:0]    prdata;
    logic                             pready;

    // Mapper state as the bench predicts it.
    logic [3:0]                  cfg_rom_exp = bmrtc_pkg::ROM_EXP_RESET;
    logic [2:0]                  cfg_ram_code = bmrtc_pkg::RAM_CODE_RESET;
    logic [7:0]                  rom_bank = 8'd1;
    logic [7:0]                  bank_sel = 8'd0;
    logic                        latch_armed = 1'b0;
    logic [4:0][7:0]             latched_clock = '0;
    logic [4:0][7:0]             live_clock = '0;
    logic [bmrtc_pkg::CNT_W-1:0] tick_count = '0;

    bus_result_t      bus_results_due [$];
    logic             use_listed_result = 1'b0;
    bus_result_t      listed_result = '0;
    int unsigned      mismatch_count = 0;
    int unsigned      quiet_cycles = 0;
    int unsigned      send_idle_pct = 0;
    int unsigned      recv_stall_pct = 0;
    logic             hold_request = 1'b0;
    int unsigned      hold_left = 0;

    stimulus_row_t directed_rows [N_DIRECTED] = '{
        '{'{bmrtc_pkg::FUNC_READ,  16'h0000, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_ROM,   22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'h3FFF, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_ROM,   22'h003FFF, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'h4000, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_ROM,   22'h004000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h2000, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h3FFF, 8'hFF}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'h7FFF, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_ROM,   22'h1FFFFF, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h2000, 8'h80}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'hA000, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_RAM,   22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'hBFFF, 8'hA5}, 1'b1,
          '{bmrtc_pkg::TGT_RAM,   22'h001FFF, 1'b1, 8'hA5, 8'h00}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h4000, 8'h03}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'hBFFF, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_RAM,   22'h007FFF, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h5FFF, 8'h04}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'hA123, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'hFF}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h4000, 8'h08}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_TICK,  16'h0000, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_TICK,  16'hFFFF, 8'hFF}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h6000, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h7FFF, 8'h01}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'hA000, 8'h00}, 1'b0, '0},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'hB000, 8'h3C}, 1'b1,
          '{bmrtc_pkg::TGT_CLOCK, 22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'hB000, 8'h00}, 1'b0, '0},
        '{'{bmrtc_pkg::FUNC_WRITE, 16'h4000, 8'h0C}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'h00}},
        '{'{bmrtc_pkg::FUNC_READ,  16'hBFFF, 8'h00}, 1'b0, '0},
        '{'{bmrtc_pkg::FUNC_READ,  16'h8000, 8'h00}, 1'b1,
          '{bmrtc_pkg::TGT_NONE,  22'h000000, 1'b0, 8'h00, 8'hFF}},
        '{'{FUNC_RESERVED, 16'hFFFF, 8'hFF}, 1'b1,
          '{bmrtc_pkg::TGT_NONE, 22'h0, 1'b0, 8'h00, 8'h00}}
    };

    phase_t phases [N_PHASES] = '{
        '{4'd5,  3'd0, 7'd0,  7'd0,  16'd150, 1'b0, 1'b0},
        '{4'd12, 3'd6, 7'd64, 7'd0,  16'd150, 1'b0, 1'b0},
        '{4'd15, 3'd7, 7'd0,  7'd64, 16'd150, 1'b1, 1'b0},
        '{4'd11, 3'd1, 7'd12, 7'd12, 16'd150, 1'b0, 1'b1},
        '{4'd13, 3'd4, 7'd0,  7'd0,  16'd150, 1'b0, 1'b0},
        '{4'd6,  3'd2, 7'd64, 7'd0,  16'd150, 1'b0, 1'b0},
        '{4'd12, 3'd3, 7'd0,  7'd64, 16'd150, 1'b0, 1'b0},
        '{4'd9,  3'd5, 7'd12, 7'd12, 16'd150, 1'b1, 1'b0}
    };

    bank_mapper_with_realtime_clock #(
        .TICKS_PER_SECOND(TICKS_PER_SEC)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_addr     (s_addr),
        .s_wdata    (s_wdata),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_target   (m_target),
        .m_mem_addr (m_mem_addr),
        .m_ram_write(m_ram_write),
        .m_ram_wdata(m_ram_wdata),
        .m_rdata    (m_rdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 aclk = ~aclk;

    function automatic bus_result_t decode_request(request_t rq);
        bus_result_t res;
        logic [3:0]  exp_eff;
        logic [21:0] rom_span;
        logic [21:0] ram_span;
        logic [7:0]  bank_val;
        logic [23:0] next_count;
        logic [2:0]  clock_idx;
        logic        carry;
        logic        is_write;
        res = '0;
        exp_eff = (cfg_rom_exp > bmrtc_pkg::ROM_EXP_MAX) ? bmrtc_pkg::ROM_EXP_MAX
                                                         : cfg_rom_exp;
        rom_span = 22'((32'd1 << (int'(exp_eff) + 10)) - 32'd1);
        ram_span = 22'((32'd1 << (int'(cfg_ram_code) + 10)) - 32'd1);
        is_write = (rq.func == bmrtc_pkg::FUNC_WRITE);
        if (rq.func == bmrtc_pkg::FUNC_TICK) begin
            next_count = tick_count + 24'd1;
            if (next_count == TICKS_PER_SEC) begin
                tick_count = '0;
                carry = 1'b1;
                for (int i = 0; i < 4; i++) begin
                    if (carry) begin
                        live_clock[i] = (live_clock[i] == CLOCK_LAST[i]) ? 8'd0
                                                                         : live_clock[i] + 8'd1;
                        carry = (live_clock[i] == 8'd0);
                    end
                end
                if (carry) begin
                    live_clock[4] = (live_clock[4] ^ DAY_MSB_BIT) | DAY_CARRY_BIT;
                end
            end else begin
                tick_count = next_count[bmrtc_pkg::CNT_W-1:0];
            end
        end else if (rq.func == bmrtc_pkg::FUNC_READ || is_write) begin
            if (rq.addr < 16'h8000 && is_write) begin
                if (rq.addr >= 16'h2000 && rq.addr < 16'h4000) begin
                    bank_val = (cfg_rom_exp <= bmrtc_pkg::ROM_EXP_7BIT) ? {1'b0, rq.wdata[6:0]}
                                                                        : rq.wdata;
                    rom_bank = (bank_val == 8'd0) ? 8'd1 : bank_val;
                end else if (rq.addr >= 16'h4000 && rq.addr < 16'h6000) begin
                    bank_sel = rq.wdata;
                end else if (rq.addr >= 16'h6000) begin
                    if (!latch_armed) begin
                        latch_armed = (rq.wdata == 8'd0);
                    end else begin
                        if (rq.wdata == 8'd1) begin
                            latched_clock = live_clock;
                        end
                        latch_armed = 1'b0;
                    end
                end
            end else if (rq.addr < 16'h4000) begin
                res.target = bmrtc_pkg::TGT_ROM;
                res.mem_addr = 22'(rq.addr) & rom_span;
            end else if (rq.addr < 16'h8000) begin
                res.target = bmrtc_pkg::TGT_ROM;
                res.mem_addr = {rom_bank, rq.addr[13:0]} & rom_span;
            end else if (rq.addr >= 16'hA000 && rq.addr < 16'hC000) begin
                if (bank_sel < bmrtc_pkg::SEL_RAM_LIMIT && cfg_ram_code != 3'd0) begin
                    res.target = bmrtc_pkg::TGT_RAM;
                    res.mem_addr = 22'({bank_sel[1:0], rq.addr[12:0]}) & ram_span;
                    if (is_write) begin
                        res.ram_write = 1'b1;
                        res.ram_wdata = rq.wdata;
                    end
                end else if (bank_sel >= bmrtc_pkg::SEL_CLOCK_FIRST
                             && bank_sel <= bmrtc_pkg::SEL_CLOCK_LAST) begin
                    res.target = bmrtc_pkg::TGT_CLOCK;
                    clock_idx = 3'(bank_sel - bmrtc_pkg::SEL_CLOCK_FIRST);
                    if (is_write) begin
                        latched_clock[clock_idx] = rq.wdata;
                    end else begin
                        res.rdata = latched_clock[clock_idx];
                    end
                end
            end
            if (!is_write && res.target == bmrtc_pkg::TGT_NONE) begin
                res.rdata = bmrtc_pkg::UNMAPPED_READ;
            end
        end
        return res;
    endfunction

    function automatic request_t random_request();
        request_t    rq;
        int unsigned pick;
        rq.func = $urandom_range(1) ? bmrtc_pkg::FUNC_WRITE : bmrtc_pkg::FUNC_READ;
        rq.addr = 16'($urandom_range(16'hFFFF));
        rq.wdata = 8'($urandom_range(255));
        pick = $urandom_range(99);
        if (pick < 20) begin
            rq.func = bmrtc_pkg::FUNC_TICK;
        end else if (pick < 35) begin
            rq.func = bmrtc_pkg::FUNC_READ;
            rq.addr = 16'($urandom_range(16'h7FFF));
        end else if (pick < 62) begin
            rq.addr = 16'($urandom_range(16'hBFFF, 16'hA000));
        end else if (pick < 70) begin
            rq.func = bmrtc_pkg::FUNC_WRITE;
            rq.addr = 16'($urandom_range(16'h3FFF, 16'h2000));
            if ($urandom_range(3) == 0) begin
                rq.wdata = $urandom_range(1) ? 8'h80 : 8'h00;
            end
        end else if (pick < 80) begin
            rq.func = bmrtc_pkg::FUNC_WRITE;
            rq.addr = 16'($urandom_range(16'h5FFF, 16'h4000));
            case ($urandom_range(2))
                0: rq.wdata = 8'($urandom_range(3));
                1: rq.wdata = 8'($urandom_range(bmrtc_pkg::SEL_CLOCK_LAST,
                                                bmrtc_pkg::SEL_CLOCK_FIRST));
                default: ;
            endcase
        end else if (pick < 90) begin
            rq.func = bmrtc_pkg::FUNC_WRITE;
            rq.addr = 16'($urandom_range(16'h7FFF, 16'h6000));
            if ($urandom_range(4) != 0) begin
                rq.wdata = 8'($urandom_range(1));
            end
        end else if (pick < 95) begin
            rq.addr = $urandom_range(1) ? 16'($urandom_range(16'h9FFF, 16'h8000))
                                        : 16'($urandom_range(16'hFFFF, 16'hC000));
        end else if (pick < 97) begin
            rq.func = FUNC_RESERVED;
        end
        return rq;
    endfunction

    task automatic offer_request(request_t rq, logic listed, bus_result_t result);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_func <= rq.func;
        s_addr <= rq.addr;
        s_wdata <= rq.wdata;
        use_listed_result <= listed;
        listed_result <= result;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (bus_results_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic write_register(bmrtc_pkg::reg_index_t idx,
                                  logic [bmrtc_pkg::PDATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) begin
            @(posedge aclk);
        end
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == bmrtc_pkg::REG_ROM_SIZE_EXP) begin
            cfg_rom_exp = value[3:0];
        end else begin
            cfg_ram_code = value[2:0];
        end
    endtask

    always @(posedge aclk) begin : result_check
        bus_result_t due;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (bus_results_due.size() == 0) begin
                    if (mismatch_count < 10) begin
                        $display("unexpected result: target %0d mem_addr %h", m_target, m_mem_addr);
                    end
                    mismatch_count++;
                end else begin
                    due = bus_results_due.pop_front();
                    if (m_target !== due.target || m_mem_addr !== due.mem_addr ||
                        m_ram_write !== due.ram_write || m_ram_wdata !== due.ram_wdata ||
                        m_rdata !== due.rdata) begin
                        if (mismatch_count < 10) begin
                            $display("mismatch: expected target %0d mem_addr %h wr %0d wdata %h rdata %h",
                                     due.target, due.mem_addr, due.ram_write, due.ram_wdata,
                                     due.rdata);
                            $display("          got target %0d mem_addr %h wr %0d wdata %h rdata %h",
                                     m_target, m_mem_addr, m_ram_write, m_ram_wdata, m_rdata);
                        end
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                due = decode_request({s_func, s_addr, s_wdata});
                bus_results_due.push_back(use_listed_result ? listed_result : due);
            end
        end
    end

    always @(posedge aclk) begin
        if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left != 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == STALL_LIMIT) begin
            $display("bank_mapper_with_realtime_clock test failed");
            $finish;
        end
    end

    initial begin : stimulus
        phase_t ph;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        for (int r = 0; r < N_DIRECTED; r++) begin
            offer_request(directed_rows[r].req, directed_rows[r].listed,
                          directed_rows[r].result);
        end
        // A short run of back-to-back ticks drives the tick counter.
        for (int t = 0; t < BURST_TICKS; t++) begin
            offer_request(request_t'{bmrtc_pkg::FUNC_TICK, 16'($urandom_range(16'hFFFF)), 8'h00},
                          1'b0, '0);
        end
        for (int p = 0; p < N_PHASES; p++) begin
            ph = phases[p];
            wait_results_drained();
            write_register(bmrtc_pkg::REG_ROM_SIZE_EXP, bmrtc_pkg::PDATA_W'(ph.rom_exp));
            write_register(bmrtc_pkg::REG_RAM_SIZE_CODE, bmrtc_pkg::PDATA_W'(ph.ram_code));
            send_idle_pct = ph.send_idle;
            recv_stall_pct = ph.recv_stall;
            if (ph.hold) begin
                hold_request = 1'b1;
            end
            for (int n = 0; n < ph.n_requests; n++) begin
                if (ph.pause && n == ph.n_requests / 2) begin
                    wait_results_drained();
                end
                offer_request(random_request(), 1'b0, '0);
            end
        end
        wait_results_drained();
        repeat (10) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("bank_mapper_with_realtime_clock test passed");
        end else begin
            $display("bank_mapper_with_realtime_clock test failed");
        end
        $finish;
    end

endmodule
